>>> rtl/core/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared codes and defaults of the segment hole allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int DEF_MAX_HOLES = 64;
    localparam int DEF_ADDR_BITS = 16;

    // configuration register widths and reset values
    localparam int MEM_SIZE_W = 17;
    localparam int POLICY_W   = 2;
    localparam int CFG_DATA_W = 17;
    localparam logic [MEM_SIZE_W-1:0] RST_MEM_SIZE = 17'd4096;

    typedef enum logic {
        CFG_MEM_SIZE = 1'b0,
        CFG_POLICY   = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_COMPACT = 2'd1,
        ST_OOM     = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POL_BEST  = 2'd0,
        POL_WORST = 2'd1,
        POL_FIRST = 2'd2,
        POL_ALT   = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/segment_hole_allocator.sv
// ----------------------------------------------------------------------------
// segment_hole_allocator
// Free-hole table with best, worst and first fit allocation and merging
// release.
// ----------------------------------------------------------------------------
// Operation: an allocate or release of a nonzero, in-range request reads every
//   table entry in turn (one table read per cycle, set by the single read port
//   of the hole memory), then updates the table and loads the result; init,
//   no-op and trivial requests go straight to loading the result.
// Throughput: one request at a time; the next request is taken once the
//   previous result has been loaded into the output register.
// Reset: synchronous, active low; the table holds one hole covering the
//   default memory size, with no clearing pass.
`default_nettype none

module segment_hole_allocator
    import sha_pkg::*;
#(
    parameter int MAX_HOLES = DEF_MAX_HOLES,
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    // configuration write port
    input  wire                                      i_cfg_we,
    input  wire                                      i_cfg_idx,
    input  wire  [CFG_DATA_W-1:0]                    i_cfg_data,
    // request stream
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: operation, region_base, region_size (from bit 0 up), zero pad
    input  wire  [((2*ADDR_BITS+3+7)/8)*8-1:0]       s_axis_tdata,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    // tdata: status, alloc_base, free_total (from bit 0 up), zero pad
    output logic [((2*ADDR_BITS+3+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int A   = ADDR_BITS;
    localparam int IB  = $clog2(MAX_HOLES);
    localparam int DW  = ((2*ADDR_BITS+3+7)/8)*8;
    localparam int MSW = (A + 1 > MEM_SIZE_W) ? A + 1 : MEM_SIZE_W;
    localparam longint unsigned LIM_L = 64'd1 << A;
    localparam longint unsigned DEF_L = 64'(RST_MEM_SIZE);
    localparam logic [A:0]   DFLT_LEN = (A+1)'((DEF_L > LIM_L) ? LIM_L : DEF_L);
    localparam logic [A+1:0] LIM_E    = (A+2)'(LIM_L);
    localparam logic [IB-1:0] LAST_IDX = IB'(MAX_HOLES - 1);

    typedef struct packed {
        logic [A:0]   hend;
        logic [A-1:0] hstart;
    } t_hole;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [MEM_SIZE_W-1:0] r_mem_size;
    logic [POLICY_W-1:0]   r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_size <= RST_MEM_SIZE;
            r_policy   <= POL_BEST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MEM_SIZE: r_mem_size <= i_cfg_data[MEM_SIZE_W-1:0];
                CFG_POLICY:   r_policy   <= i_cfg_data[POLICY_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Request fields
    // ---------------------------------------------------------------------
    logic [1:0]   in_op;
    logic [A-1:0] in_base;
    logic [A:0]   in_size;
    logic [A+1:0] in_end;
    logic         in_acc;

    assign in_op   = s_axis_tdata[1:0];
    assign in_base = s_axis_tdata[A+1:2];
    assign in_size = s_axis_tdata[2*A+2:A+2];
    assign in_end  = {2'b00, in_base} + {1'b0, in_size};
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // init length: memory size clamped to the address space
    logic [MSW-1:0] ms_ext;
    logic [MSW-1:0] ms_lim;
    logic [A:0]     init_len;

    assign ms_ext   = MSW'(r_mem_size);
    assign ms_lim   = MSW'(LIM_L);
    assign init_len = (ms_ext > ms_lim) ? (A+1)'(ms_lim) : (A+1)'(ms_ext);

    // ---------------------------------------------------------------------
    // Hole memory: one write and one registered read per cycle
    // ---------------------------------------------------------------------
    t_hole          mem [MAX_HOLES];
    t_hole          r_rd_data;
    logic [IB-1:0]  rd_addr;
    logic           wr_en;
    logic [IB-1:0]  wr_addr;
    t_hole          wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // ---------------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------------
    t_state          r_state, n_state;
    logic [MAX_HOLES-1:0] r_valid, n_valid;
    logic            r_dflt, n_dflt;     // entry 0 still holds its reset hole
    logic [A:0]      r_free, n_free;

    logic [1:0]      r_op, n_op;
    logic [A-1:0]    r_base, n_base;
    logic [A:0]      r_size, n_size;
    logic [A+1:0]    r_rend, n_rend;

    logic [IB-1:0]   r_idx, n_idx;
    logic            r_issued, n_issued;
    logic            r_pv, n_pv;
    logic [IB-1:0]   r_pidx, n_pidx;

    // allocate pick
    logic            r_pk_vld, n_pk_vld;
    logic [IB-1:0]   r_pk_idx, n_pk_idx;
    logic [A-1:0]    r_pk_start, n_pk_start;
    logic [A:0]      r_pk_end, n_pk_end;
    logic [A:0]      r_pk_len, n_pk_len;

    // release neighbours and free slot
    logic            r_abort, n_abort;
    logic            r_lf_vld, n_lf_vld;
    logic [IB-1:0]   r_lf_idx, n_lf_idx;
    logic [A-1:0]    r_lf_start, n_lf_start;
    logic            r_rt_vld, n_rt_vld;
    logic [IB-1:0]   r_rt_idx, n_rt_idx;
    logic [A:0]      r_rt_end, n_rt_end;
    logic            r_fs_vld, n_fs_vld;
    logic [IB-1:0]   r_fs_idx, n_fs_idx;

    // result
    logic [1:0]      r_status, n_status;
    logic [A-1:0]    r_grant, n_grant;
    logic            r_out_vld, n_out_vld;
    logic [1:0]      r_o_status, n_o_status;
    logic [A-1:0]    r_o_base, n_o_base;
    logic [A:0]      r_o_free, n_o_free;

    // entry under evaluation
    t_hole           cur;
    logic            cur_v;
    logic [A:0]      cur_len;
    logic            better;

    assign rd_addr = r_idx;
    assign cur     = (r_dflt && r_pidx == '0) ? t_hole'{hend: DFLT_LEN, hstart: '0}
                                              : r_rd_data;
    assign cur_v   = r_valid[r_pidx];
    assign cur_len = cur.hend - {1'b0, cur.hstart};

    always_comb begin
        case (t_policy'(r_policy))
            POL_BEST:  better = cur_len < r_pk_len ||
                                (cur_len == r_pk_len && cur.hstart < r_pk_start);
            POL_WORST: better = cur_len > r_pk_len ||
                                (cur_len == r_pk_len && cur.hstart < r_pk_start);
            default:   better = cur.hstart < r_pk_start;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_dflt     = r_dflt;
        n_free     = r_free;
        n_op       = r_op;
        n_base     = r_base;
        n_size     = r_size;
        n_rend     = r_rend;
        n_idx      = r_idx;
        n_issued   = r_issued;
        n_pv       = 1'b0;
        n_pidx     = r_pidx;
        n_pk_vld   = r_pk_vld;
        n_pk_idx   = r_pk_idx;
        n_pk_start = r_pk_start;
        n_pk_end   = r_pk_end;
        n_pk_len   = r_pk_len;
        n_abort    = r_abort;
        n_lf_vld   = r_lf_vld;
        n_lf_idx   = r_lf_idx;
        n_lf_start = r_lf_start;
        n_rt_vld   = r_rt_vld;
        n_rt_idx   = r_rt_idx;
        n_rt_end   = r_rt_end;
        n_fs_vld   = r_fs_vld;
        n_fs_idx   = r_fs_idx;
        n_status   = r_status;
        n_grant    = r_grant;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_base   = r_o_base;
        n_o_free   = r_o_free;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        s_axis_tready = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op       = in_op;
                    n_base     = in_base;
                    n_size     = in_size;
                    n_rend     = in_end;
                    n_status   = ST_OK;
                    n_grant    = '0;
                    n_idx      = '0;
                    n_issued   = 1'b0;
                    n_pk_vld   = 1'b0;
                    n_abort    = 1'b0;
                    n_lf_vld   = 1'b0;
                    n_rt_vld   = 1'b0;
                    n_fs_vld   = 1'b0;
                    n_state    = S_DONE;
                    case (t_op'(in_op))
                        OP_ALLOC: begin
                            if (in_size != '0) n_state = S_SCAN;
                        end
                        OP_RELEASE: begin
                            if (in_size != '0 && in_end <= LIM_E) n_state = S_SCAN;
                        end
                        OP_INIT: begin
                            // drop every hole, lay one over the whole memory
                            n_valid    = '0;
                            n_valid[0] = (init_len != '0);
                            n_dflt     = 1'b0;
                            n_free     = init_len;
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = t_hole'{hend: init_len, hstart: '0};
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN: begin
                // issue one read a cycle, evaluate the entry read last cycle
                if (!r_issued) begin
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_issued = 1'b1;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_pv) begin
                    if (r_op == OP_ALLOC) begin
                        if (cur_v && cur_len >= r_size && (!r_pk_vld || better)) begin
                            n_pk_vld   = 1'b1;
                            n_pk_idx   = r_pidx;
                            n_pk_start = cur.hstart;
                            n_pk_end   = cur.hend;
                            n_pk_len   = cur_len;
                        end
                    end else if (!cur_v) begin
                        if (!r_fs_vld) begin
                            n_fs_vld = 1'b1;
                            n_fs_idx = r_pidx;
                        end
                    end else begin
                        if ({2'b00, cur.hstart} < r_rend && {1'b0, r_base} < cur.hend) begin
                            n_abort = 1'b1;
                        end
                        if (cur.hend == {1'b0, r_base}) begin
                            n_lf_vld   = 1'b1;
                            n_lf_idx   = r_pidx;
                            n_lf_start = cur.hstart;
                        end
                        if ({2'b00, cur.hstart} == r_rend) begin
                            n_rt_vld = 1'b1;
                            n_rt_idx = r_pidx;
                            n_rt_end = cur.hend;
                        end
                    end
                    if (r_pidx == LAST_IDX) n_state = S_UPD;
                end
            end

            S_UPD: begin
                n_state = S_DONE;
                wr_en   = 1'b1;
                if (r_op == OP_ALLOC) begin
                    if (r_pk_vld) begin
                        // cut from the front, drop the hole once empty
                        wr_addr  = r_pk_idx;
                        wr_data  = t_hole'{hend: r_pk_end,
                                           hstart: r_pk_start + r_size[A-1:0]};
                        if (r_pk_len == r_size) n_valid[r_pk_idx] = 1'b0;
                        n_grant  = r_pk_start;
                        n_free   = r_free - r_size;
                    end else begin
                        wr_en    = 1'b0;
                        n_status = (r_free >= r_size) ? ST_COMPACT : ST_OOM;
                    end
                end else if (r_abort) begin
                    wr_en = 1'b0;
                end else if (r_lf_vld && r_rt_vld) begin
                    wr_addr  = r_lf_idx;
                    wr_data  = t_hole'{hend: r_rt_end, hstart: r_lf_start};
                    n_valid[r_rt_idx] = 1'b0;
                    n_free   = r_free + r_size;
                end else if (r_lf_vld) begin
                    wr_addr  = r_lf_idx;
                    wr_data  = t_hole'{hend: r_rend[A:0], hstart: r_lf_start};
                    n_free   = r_free + r_size;
                end else if (r_rt_vld) begin
                    wr_addr  = r_rt_idx;
                    wr_data  = t_hole'{hend: r_rt_end, hstart: r_base};
                    n_free   = r_free + r_size;
                end else if (r_fs_vld) begin
                    wr_addr  = r_fs_idx;
                    wr_data  = t_hole'{hend: r_rend[A:0], hstart: r_base};
                    n_valid[r_fs_idx] = 1'b1;
                    n_free   = r_free + r_size;
                end else begin
                    wr_en    = 1'b0;
                    n_status = ST_FULL;
                end
                if (wr_en && wr_addr == '0) n_dflt = 1'b0;
            end

            S_DONE: begin
                // hold until the output register is free
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_o_status = r_status;
                    n_o_base   = r_grant;
                    n_o_free   = r_free;
                    n_state    = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= MAX_HOLES'(1);
            r_dflt     <= 1'b1;
            r_free     <= DFLT_LEN;
            r_out_vld  <= 1'b0;
            r_pv       <= 1'b0;
            r_issued   <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_dflt     <= n_dflt;
            r_free     <= n_free;
            r_out_vld  <= n_out_vld;
            r_pv       <= n_pv;
            r_issued   <= n_issued;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_base     <= n_base;
        r_size     <= n_size;
        r_rend     <= n_rend;
        r_pidx     <= n_pidx;
        r_pk_vld   <= n_pk_vld;
        r_pk_idx   <= n_pk_idx;
        r_pk_start <= n_pk_start;
        r_pk_end   <= n_pk_end;
        r_pk_len   <= n_pk_len;
        r_abort    <= n_abort;
        r_lf_vld   <= n_lf_vld;
        r_lf_idx   <= n_lf_idx;
        r_lf_start <= n_lf_start;
        r_rt_vld   <= n_rt_vld;
        r_rt_idx   <= n_rt_idx;
        r_rt_end   <= n_rt_end;
        r_fs_vld   <= n_fs_vld;
        r_fs_idx   <= n_fs_idx;
        r_status   <= n_status;
        r_grant    <= n_grant;
        r_o_status <= n_o_status;
        r_o_base   <= n_o_base;
        r_o_free   <= n_o_free;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DW'({r_o_free, r_o_base, r_o_status});

endmodule

`default_nettype wire

>>> rtl/core/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the segment hole allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_checker
    import sha_pkg::*;
#(
    parameter int ADDR_BITS = DEF_ADDR_BITS
) (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [((2*ADDR_BITS+3+7)/8)*8-1:0]  m_axis_tdata
);

    localparam int A = ADDR_BITS;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");

    // a base is granted only with ok status
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[A+1:2] == '0)
        else $error("base granted on failed request");

endmodule

bind segment_hole_allocator sha_checker #(.ADDR_BITS(ADDR_BITS)) u_sha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
